// File: sv/tcsp_pkg.sv
// Package with the shared constants, types and helper functions of the command slot pool.
`timescale 1ns / 1ps

package tcsp_pkg;

   localparam int POOL_SLOTS    = 16;
   localparam int SLOT_W        = $clog2(POOL_SLOTS);
   localparam int MAX_FIRED     = 16;
   localparam int FIRE_CNT_W    = $clog2(MAX_FIRED + 1);
   localparam int MS_PER_SECOND = 1000;
   localparam int DUE_W         = 32;
   localparam int PROD_W        = 18;

   typedef enum logic [1:0] {
      MODE_OBTAIN = 2'd0,
      MODE_SUBMIT = 2'd1,
      MODE_SCAN   = 2'd2
   } mode_type;

   typedef enum logic [1:0] {
      KIND_OBTAIN = 2'd0,
      KIND_SUBMIT = 2'd1,
      KIND_FIRED  = 2'd2,
      KIND_DONE   = 2'd3
   } kind_type;

   typedef enum logic {
      REG_EXEC_ENABLE = 1'b0,
      REG_CANCEL_CODE = 1'b1
   } reg_index_type;

   // One slot as it is kept in the slot memory.
   typedef struct packed {
      logic [DUE_W-1:0] due;
      logic [7:0]       repeats;
      logic [7:0]       delay;
      logic [7:0]       action;
      logic [7:0]       target;
      logic [7:0]       id;
   } slot_entry_type;

   typedef struct packed {
      kind_type   kind;
      logic       ok;
      logic [3:0] slot;
      logic [7:0] id;
      logic [7:0] target;
      logic [7:0] action;
      logic       last;
   } rsp_item_type;

   // Due time of a command that is scheduled now with the given delay in seconds.
   function automatic logic [DUE_W-1:0] sched_due(input logic [DUE_W-1:0] now,
                                                  input logic [7:0] delay);
      logic [PROD_W-1:0] prod;
      prod = PROD_W'(delay) * PROD_W'(MS_PER_SECOND);
      return now + DUE_W'(prod);
   endfunction

   function automatic rsp_item_type make_rsp(input kind_type kind, input logic ok,
                                             input logic [3:0] slot, input logic [7:0] id,
                                             input logic [7:0] target,
                                             input logic [7:0] action, input logic last);
      rsp_item_type r;
      r.kind   = kind;
      r.ok     = ok;
      r.slot   = slot;
      r.id     = id;
      r.target = target;
      r.action = action;
      r.last   = last;
      return r;
   endfunction

endpackage

// File: sv/tcsp_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
`timescale 1ns / 1ps

module tcsp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: sv/timed_command_slot_pool.sv
// Top level of the timed command slot pool: control sequencer, slot memory and register port.
//
//  channel | direction | handshake           | contents
//  req     | in        | req_tvalid/tready   | tuser: mode; tdata: slot, command, now_ms
//  rsp     | out       | rsp_tvalid/tready   | tuser: kind; tdata: ok, slot, fired fields
//  csr     | in        | APB psel/penable    | exec_enable at 0x0, cancel_code at 0x4
//
// One item is worked on at a time. During a scan, each cancellation with a nonzero id searches
// the slot memory for a command with that id through the single memory read port. Reset clears
// the valid bits, so no clearing pass is needed. A stalled result holds the sequencer in place
// until the result register frees up.
`timescale 1ns / 1ps

module timed_command_slot_pool
   import tcsp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // tdata from bit 0: slot[3:0], cmd_id[11:4], target_code[19:12], action_code[27:20],
   // delay_seconds[35:28], repeat_count[43:36], now_ms[75:44], zero fill[79:76]
   input  logic [79:0] req_tdata,
   // tuser: mode[1:0]
   input  logic [1:0]  req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // tdata from bit 0: ok[0], slot_out[4:1], fired_id[12:5], fired_target[20:13],
   // fired_action[28:21], zero fill[31:29]
   output logic [31:0] rsp_tdata,
   // tuser: kind[1:0]
   output logic [1:0]  rsp_tuser,
   output logic        rsp_tlast,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(POOL_SLOTS - 1);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_OBT_HINT,
      ST_OBT_WALK,
      ST_SUBMIT,
      ST_SCAN_RD,
      ST_SCAN_EVAL,
      ST_CAN_RD,
      ST_CAN_CMP,
      ST_DONE
   } state_type;

   state_type             state_ff;
   logic [SLOT_W-1:0]     slot_idx_ff;
   logic [SLOT_W-1:0]     srch_idx_ff;
   logic [SLOT_W-1:0]     hint_ff;
   logic [FIRE_CNT_W-1:0] fire_cnt_ff;
   logic [POOL_SLOTS-1:0] valid_ff;
   logic [7:0]            cur_id_ff;

   logic [3:0]       req_slot_ff;
   logic [7:0]       req_id_ff;
   logic [7:0]       req_target_ff;
   logic [7:0]       req_action_ff;
   logic [7:0]       req_delay_ff;
   logic [7:0]       req_repeats_ff;
   logic [DUE_W-1:0] now_ff;

   logic         rsp_valid_ff;
   rsp_item_type rsp_ff;

   logic       exec_enable_ff;
   logic [7:0] cancel_code_ff;

   logic              out_free;
   logic              last_slot;
   logic              last_srch;
   logic              sub_in_range;
   logic              sub_accept;
   logic [SLOT_W-1:0] sub_addr;
   logic              resched;
   logic              csr_write;

   logic                        ram_wr_en;
   logic [SLOT_W-1:0]           ram_wr_addr;
   slot_entry_type              ram_wr_entry;
   logic                        ram_rd_en;
   logic [SLOT_W-1:0]           ram_rd_addr;
   logic [$bits(slot_entry_type)-1:0] ram_rd_data;
   slot_entry_type              rd_entry;

   function automatic logic [SLOT_W-1:0] wrap_next(input logic [SLOT_W-1:0] x);
      return (x == LAST_SLOT) ? '0 : x + 1'b1;
   endfunction

   assign out_free     = !rsp_valid_ff || rsp_tready;
   assign last_slot    = (slot_idx_ff == LAST_SLOT);
   assign last_srch    = (srch_idx_ff == LAST_SLOT);
   assign sub_in_range = (32'(req_slot_ff) < POOL_SLOTS);
   assign sub_accept   = sub_in_range && (req_target_ff != 8'd0) && (req_action_ff != 8'd0);
   assign sub_addr     = SLOT_W'(req_slot_ff);
   assign rd_entry     = slot_entry_type'(ram_rd_data);

   // A timed command that is due and still has repeats gets written back in place.
   assign resched = (state_ff == ST_SCAN_EVAL) && out_free
                    && (rd_entry.action != cancel_code_ff) && (rd_entry.delay != 8'd0)
                    && (rd_entry.due <= now_ff) && (rd_entry.repeats != 8'd0);

   always_comb begin
      ram_wr_en    = 1'b0;
      ram_wr_addr  = sub_addr;
      ram_wr_entry = rd_entry;
      if ((state_ff == ST_SUBMIT) && out_free && sub_accept) begin
         ram_wr_en            = 1'b1;
         ram_wr_entry.id      = req_id_ff;
         ram_wr_entry.target  = req_target_ff;
         ram_wr_entry.action  = req_action_ff;
         ram_wr_entry.delay   = req_delay_ff;
         ram_wr_entry.repeats = req_repeats_ff;
         ram_wr_entry.due     = (req_delay_ff != 8'd0) ? sched_due(now_ff, req_delay_ff) : '0;
      end else if (resched) begin
         ram_wr_en            = 1'b1;
         ram_wr_addr          = slot_idx_ff;
         ram_wr_entry.due     = sched_due(now_ff, rd_entry.delay);
         ram_wr_entry.repeats = rd_entry.repeats - 8'd1;
      end
   end

   assign ram_rd_en   = (state_ff == ST_SCAN_RD) || (state_ff == ST_CAN_RD);
   assign ram_rd_addr = (state_ff == ST_CAN_RD) ? srch_idx_ff : slot_idx_ff;

   tcsp_ram #(
      .WIDTH($bits(slot_entry_type)),
      .DEPTH(POOL_SLOTS)
   ) u_slot_ram (
      .clock  (clock),
      .wr_en  (ram_wr_en),
      .wr_addr(ram_wr_addr),
      .wr_data(ram_wr_entry),
      .rd_en  (ram_rd_en),
      .rd_addr(ram_rd_addr),
      .rd_data(ram_rd_data)
   );

   assign req_tready = (state_ff == ST_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         slot_idx_ff  <= '0;
         srch_idx_ff  <= '0;
         hint_ff      <= '0;
         fire_cnt_ff  <= '0;
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (req_tvalid) begin
                  req_slot_ff    <= req_tdata[3:0];
                  req_id_ff      <= req_tdata[11:4];
                  req_target_ff  <= req_tdata[19:12];
                  req_action_ff  <= req_tdata[27:20];
                  req_delay_ff   <= req_tdata[35:28];
                  req_repeats_ff <= req_tdata[43:36];
                  now_ff         <= req_tdata[75:44];
                  slot_idx_ff    <= '0;
                  fire_cnt_ff    <= '0;
                  case (mode_type'(req_tuser))
                     MODE_OBTAIN: state_ff <= ST_OBT_HINT;
                     MODE_SUBMIT: state_ff <= ST_SUBMIT;
                     MODE_SCAN:   state_ff <= exec_enable_ff ? ST_SCAN_RD : ST_DONE;
                     default:     state_ff <= ST_IDLE;
                  endcase
               end
            end
            ST_OBT_HINT: begin
               if (valid_ff[hint_ff]) begin
                  hint_ff  <= wrap_next(hint_ff);
                  state_ff <= ST_OBT_WALK;
               end else if (out_free) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_ff       <= make_rsp(KIND_OBTAIN, 1'b1, 4'(hint_ff), 8'd0, 8'd0,
                                           8'd0, 1'b1);
                  hint_ff      <= wrap_next(hint_ff);
                  state_ff     <= ST_IDLE;
               end
            end
            ST_OBT_WALK: begin
               if (!valid_ff[slot_idx_ff]) begin
                  if (out_free) begin
                     rsp_valid_ff <= 1'b1;
                     rsp_ff       <= make_rsp(KIND_OBTAIN, 1'b1, 4'(slot_idx_ff), 8'd0, 8'd0,
                                              8'd0, 1'b1);
                     hint_ff      <= wrap_next(slot_idx_ff);
                     state_ff     <= ST_IDLE;
                  end
               end else if (last_slot) begin
                  if (out_free) begin
                     rsp_valid_ff <= 1'b1;
                     rsp_ff       <= make_rsp(KIND_OBTAIN, 1'b0, 4'd0, 8'd0, 8'd0, 8'd0, 1'b1);
                     state_ff     <= ST_IDLE;
                  end
               end else begin
                  slot_idx_ff <= slot_idx_ff + 1'b1;
               end
            end
            ST_SUBMIT: begin
               if (out_free) begin
                  if (sub_in_range) begin
                     valid_ff[sub_addr] <= sub_accept;
                  end
                  rsp_valid_ff <= 1'b1;
                  rsp_ff       <= make_rsp(KIND_SUBMIT, sub_accept, req_slot_ff, 8'd0, 8'd0,
                                           8'd0, 1'b1);
                  state_ff     <= ST_IDLE;
               end
            end
            ST_SCAN_RD: begin
               if (fire_cnt_ff == FIRE_CNT_W'(MAX_FIRED)) begin
                  state_ff <= ST_DONE;
               end else if (valid_ff[slot_idx_ff]) begin
                  state_ff <= ST_SCAN_EVAL;
               end else begin
                  slot_idx_ff <= slot_idx_ff + 1'b1;
                  state_ff    <= last_slot ? ST_DONE : ST_SCAN_RD;
               end
            end
            ST_SCAN_EVAL: begin
               if (rd_entry.action == cancel_code_ff) begin
                  if (rd_entry.id != 8'd0) begin
                     cur_id_ff   <= rd_entry.id;
                     srch_idx_ff <= '0;
                     state_ff    <= ST_CAN_RD;
                  end else begin
                     valid_ff[slot_idx_ff] <= 1'b0;
                     slot_idx_ff           <= slot_idx_ff + 1'b1;
                     state_ff              <= last_slot ? ST_DONE : ST_SCAN_RD;
                  end
               end else if (rd_entry.delay == 8'd0 && rd_entry.repeats != 8'd0) begin
                  // An untimed repeating command is dropped without firing.
                  valid_ff[slot_idx_ff] <= 1'b0;
                  slot_idx_ff           <= slot_idx_ff + 1'b1;
                  state_ff              <= last_slot ? ST_DONE : ST_SCAN_RD;
               end else if (rd_entry.delay == 8'd0 || rd_entry.due <= now_ff) begin
                  if (out_free) begin
                     rsp_valid_ff <= 1'b1;
                     rsp_ff       <= make_rsp(KIND_FIRED, 1'b0, 4'(slot_idx_ff), rd_entry.id,
                                              rd_entry.target, rd_entry.action, 1'b0);
                     fire_cnt_ff  <= fire_cnt_ff + 1'b1;
                     if (rd_entry.delay == 8'd0 || rd_entry.repeats == 8'd0) begin
                        valid_ff[slot_idx_ff] <= 1'b0;
                     end
                     slot_idx_ff <= slot_idx_ff + 1'b1;
                     state_ff    <= last_slot ? ST_DONE : ST_SCAN_RD;
                  end
               end else begin
                  slot_idx_ff <= slot_idx_ff + 1'b1;
                  state_ff    <= last_slot ? ST_DONE : ST_SCAN_RD;
               end
            end
            ST_CAN_RD: begin
               if (srch_idx_ff == slot_idx_ff || !valid_ff[srch_idx_ff]) begin
                  if (last_srch) begin
                     valid_ff[slot_idx_ff] <= 1'b0;
                     slot_idx_ff           <= slot_idx_ff + 1'b1;
                     state_ff              <= last_slot ? ST_DONE : ST_SCAN_RD;
                  end else begin
                     srch_idx_ff <= srch_idx_ff + 1'b1;
                  end
               end else begin
                  state_ff <= ST_CAN_CMP;
               end
            end
            ST_CAN_CMP: begin
               if (rd_entry.id == cur_id_ff || last_srch) begin
                  if (rd_entry.id == cur_id_ff) begin
                     valid_ff[srch_idx_ff] <= 1'b0;
                  end
                  valid_ff[slot_idx_ff] <= 1'b0;
                  slot_idx_ff           <= slot_idx_ff + 1'b1;
                  state_ff              <= last_slot ? ST_DONE : ST_SCAN_RD;
               end else begin
                  srch_idx_ff <= srch_idx_ff + 1'b1;
                  state_ff    <= ST_CAN_RD;
               end
            end
            ST_DONE: begin
               if (out_free) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_ff       <= make_rsp(KIND_DONE, 1'b0, 4'd0, 8'd0, 8'd0, 8'd0, 1'b1);
                  state_ff     <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_ff.kind;
   assign rsp_tlast  = rsp_ff.last;
   assign rsp_tdata  = {3'b000, rsp_ff.action, rsp_ff.target, rsp_ff.id, rsp_ff.slot,
                        rsp_ff.ok};

   // Register port: the index is the word address, the low address bits are ignored.
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         exec_enable_ff <= 1'b1;
         cancel_code_ff <= 8'hff;
      end else if (csr_write) begin
         case (reg_index_type'(csr_paddr[2]))
            REG_EXEC_ENABLE: exec_enable_ff <= csr_pwdata[0];
            REG_CANCEL_CODE: cancel_code_ff <= csr_pwdata[7:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (reg_index_type'(csr_paddr[2]))
         REG_EXEC_ENABLE: csr_prdata = {31'd0, exec_enable_ff};
         REG_CANCEL_CODE: csr_prdata = {24'd0, cancel_code_ff};
         default:         csr_prdata = 32'd0;
      endcase
   end

endmodule
